[sv/assert_macros.svh]
// Assertion macros shared by the RTL of the bag table.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   `ASSERT_HOLDS(label, clk, rst, !(cond), msg)

`endif

[sv/bmt_pkg.sv]
// Package for the bag table: operation codes, sequencer states, result record.
// No dependencies; used by bmt_engine and bounded_multiset_table.
`timescale 1ns / 1ps

package bmt_pkg;

   localparam int OP_W       = 3;
   localparam int COUNT_W    = 5;
   localparam int OUT_ITEM_W = 32;

   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_ADD    = 3'd0;
   localparam op_type OP_REMOVE = 3'd1;
   localparam op_type OP_COUNT  = 3'd2;
   localparam op_type OP_CLEAR  = 3'd3;
   localparam op_type OP_LIST   = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MOVE,
      ST_LIST,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic                  success;
      logic [COUNT_W-1:0]    match_count;
      logic [COUNT_W-1:0]    size_after;
      logic [OUT_ITEM_W-1:0] item_out;
      logic                  item_valid;
      logic                  last;
   } result_type;

endpackage

[sv/bmt_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module bmt_ram #(
   parameter  int WIDTH  = 32,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/bmt_engine.sv]
// Sequencer of the bag table: entry count, memory walk, compare and move.
// Depends on bmt_pkg and assert_macros.svh; drives one bmt_ram instance.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmt_engine #(
   parameter  int CAPACITY   = 16,
   parameter  int ITEM_WIDTH = 32,
   localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bmt_pkg::op_type                   req_op,
   input  logic [bmt_pkg::OUT_ITEM_W-1:0]    req_value,
   output logic                              res_valid,
   input  logic                              res_ready,
   output bmt_pkg::result_type               res,
   output logic                              wr_en,
   output logic [ADDR_W-1:0]                 wr_addr,
   output logic [ITEM_WIDTH-1:0]             wr_data,
   output logic                              rd_en,
   output logic [ADDR_W-1:0]                 rd_addr,
   input  logic [ITEM_WIDTH-1:0]             rd_data
);

   import bmt_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   state_type             state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic                  chk_ff, chk_in;
   op_type                op_ff, op_in;
   logic [ITEM_WIDTH-1:0] val_ff, val_in;
   logic [CW-1:0]         match_ff, match_in;
   logic [ADDR_W-1:0]     pos_ff, pos_in;
   logic                  ok_ff, ok_in;

   logic [CW-1:0]         idx_dec;
   logic [CW-1:0]         cnt_dec;
   logic [CW-1:0]         match_nx;
   logic                  hit;
   logic                  more;
   logic                  cnt_full;

   // chk_ff: read data for slot idx_ff-1 is on rd_data this cycle
   assign idx_dec  = CW'(idx_ff - 1'b1);
   assign cnt_dec  = CW'(cnt_ff - 1'b1);
   assign hit      = chk_ff && (rd_data == val_ff);
   assign match_nx = hit ? CW'(match_ff + 1'b1) : match_ff;
   assign more     = idx_ff < cnt_ff;
   assign cnt_full = cnt_ff >= CW'(CAPACITY);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         idx_ff   <= '0;
         chk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
         chk_ff   <= chk_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      val_ff   <= val_in;
      match_ff <= match_in;
      pos_ff   <= pos_in;
      ok_ff    <= ok_in;
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      chk_in    = chk_ff;
      op_in     = op_ff;
      val_in    = val_ff;
      match_in  = match_ff;
      pos_in    = pos_ff;
      ok_in     = ok_ff;
      req_ready = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = idx_ff[ADDR_W-1:0];
      wr_en     = 1'b0;
      wr_addr   = cnt_ff[ADDR_W-1:0];
      wr_data   = val_ff;
      res_valid = 1'b0;
      res       = '0;
      res.size_after = COUNT_W'(cnt_ff);

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_op;
               val_in   = ITEM_WIDTH'(req_value);
               idx_in   = '0;
               chk_in   = 1'b0;
               match_in = '0;
               ok_in    = 1'b0;
               state_in = ST_RESULT;
               case (req_op)
                  OP_ADD: begin
                     if (!cnt_full) begin
                        wr_en   = 1'b1;
                        wr_addr = cnt_ff[ADDR_W-1:0];
                        wr_data = ITEM_WIDTH'(req_value);
                        cnt_in  = CW'(cnt_ff + 1'b1);
                        ok_in   = 1'b1;
                     end
                  end
                  OP_REMOVE, OP_COUNT: begin
                     state_in = ST_SCAN;
                  end
                  OP_CLEAR: begin
                     cnt_in = '0;
                     ok_in  = 1'b1;
                  end
                  OP_LIST: begin
                     ok_in = 1'b1;
                     if (cnt_ff != '0) begin
                        state_in = ST_LIST;
                     end
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if ((op_ff == OP_REMOVE) && hit) begin
               // first match: fetch the last entry to fill the hole
               pos_in   = idx_dec[ADDR_W-1:0];
               rd_en    = 1'b1;
               rd_addr  = cnt_dec[ADDR_W-1:0];
               ok_in    = 1'b1;
               chk_in   = 1'b0;
               state_in = ST_MOVE;
            end else begin
               match_in = match_nx;
               chk_in   = more;
               if (more) begin
                  rd_en  = 1'b1;
                  idx_in = CW'(idx_ff + 1'b1);
               end else begin
                  ok_in    = (match_nx != '0);
                  state_in = ST_RESULT;
               end
            end
         end

         ST_MOVE: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = rd_data;
            cnt_in   = cnt_dec;
            state_in = ST_RESULT;
         end

         ST_LIST: begin
            res_valid      = chk_ff;
            res.success    = 1'b1;
            res.item_out   = OUT_ITEM_W'(rd_data);
            res.item_valid = 1'b1;
            res.last       = !more;
            if (more && (!chk_ff || res_ready)) begin
               rd_en  = 1'b1;
               idx_in = CW'(idx_ff + 1'b1);
               chk_in = 1'b1;
            end else if (chk_ff && res_ready) begin
               chk_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end

         ST_RESULT: begin
            res_valid       = 1'b1;
            res.success     = ok_ff;
            res.match_count = COUNT_W'(match_ff);
            res.last        = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `ASSERT_HOLDS(a_cnt_bound, clock, reset, cnt_ff <= CW'(CAPACITY), "entry count above capacity")
   `ASSERT_NEVER(a_rw_same_slot, clock, reset, wr_en && rd_en && (wr_addr == rd_addr), "read and write hit one slot")
   `ASSERT_HOLDS(a_move_shrinks, clock, reset, (state_ff == ST_MOVE) |=> (cnt_ff == $past(cnt_dec)), "remove did not shrink count")
   `ASSERT_NEVER(a_chk_idx, clock, reset, chk_ff && (idx_ff == '0) && ((state_ff == ST_SCAN) || (state_ff == ST_LIST)), "pending read without issued slot")

endmodule

[sv/bounded_multiset_table.sv]
// Top level of the bag table: slot memory, sequencer and result output register.
// Depends on bmt_pkg, bmt_ram and bmt_engine.
`timescale 1ns / 1ps

// Fixed-capacity bag of values held in one single-port-read slot memory.
// Add, clear and unused operation codes need no memory walk. Count walks all
// entries held and remove walks them up to its first match; list streams one
// entry per cycle while the output is not stalled. The walk is paced by the
// single read port of the slot memory, which it visits one slot per cycle.
// Slots are only read below the entry count, so no clearing pass runs after
// reset. The result register lets a new transaction be taken while the
// previous result still waits.
module bounded_multiset_table #(
   parameter int CAPACITY   = 16,
   parameter int ITEM_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] item_value
   input  logic [2:0]  req_tuser,   // [2:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [0] success, [5:1] match_count, [10:6] size_after,
                                    // [42:11] item_out, [47:43] zero
   output logic        rsp_tuser,   // [0] item_valid
   output logic        rsp_tlast
);

   import bmt_pkg::*;

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int PAD_W  = 48 - (1 + 2 * COUNT_W + OUT_ITEM_W);

   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ITEM_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ITEM_WIDTH-1:0] rd_data;
   logic                  res_valid;
   logic                  res_ready;
   result_type            res;
   logic                  rsp_valid_ff;
   result_type            rsp_data_ff;

   bmt_ram #(
      .WIDTH (ITEM_WIDTH),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bmt_engine #(
      .CAPACITY   (CAPACITY),
      .ITEM_WIDTH (ITEM_WIDTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tuser),
      .req_value (req_tdata),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_data_ff.item_out, rsp_data_ff.size_after,
                        rsp_data_ff.match_count, rsp_data_ff.success};
   assign rsp_tuser  = rsp_data_ff.item_valid;
   assign rsp_tlast  = rsp_data_ff.last;

endmodule

[tb/bag_result_checker.sv]
// Result checker for the bag table: mirrors the bag contents from accepted requests
// and compares every accepted response against the predicted one, in order.
// Depends on bmt_pkg; instantiated by bounded_multiset_table_tb.
`timescale 1ns / 1ps

module bag_result_checker #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] item_value
   input  logic [2:0]  req_tuser,   // [2:0] operation
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // [0] success, [5:1] match_count, [10:6] size_after,
                                    // [42:11] item_out, [47:43] zero
   input  logic        rsp_tuser,   // [0] item_valid
   input  logic        rsp_tlast,
   output int          mismatches,
   output int          results_checked,
   output int          results_pending
);

   import bmt_pkg::*;

   localparam int MAX_REPORTS = 20;
   localparam int RING_DEPTH  = 64;

   logic [31:0]        slot_values [CAPACITY];
   logic [COUNT_W-1:0] bag_size;
   result_type         expected_ring [RING_DEPTH];
   int                 ring_head;
   int                 ring_tail;

   function automatic void queue_result(logic ok, logic [COUNT_W-1:0] match_num,
                                        logic [31:0] item, logic valid, logic fin);
      result_type r;
      r.success     = ok;
      r.match_count = match_num;
      r.size_after  = bag_size;
      r.item_out    = item;
      r.item_valid  = valid;
      r.last        = fin;
      expected_ring[ring_tail % RING_DEPTH] = r;
      ring_tail++;
   endfunction

   function automatic void apply_bag_op(op_type op, logic [31:0] value);
      int found_at;
      int hits;
      int i;
      found_at = -1;
      hits     = 0;
      case (op)
         OP_ADD: begin
            if (bag_size >= CAPACITY) begin
               queue_result(1'b0, '0, '0, 1'b0, 1'b1);
            end else begin
               slot_values[bag_size] = value;
               bag_size = bag_size + 1'b1;
               queue_result(1'b1, '0, '0, 1'b0, 1'b1);
            end
         end
         OP_REMOVE: begin
            for (i = 0; i < bag_size; i++)
               if (found_at < 0 && slot_values[i] == value) found_at = i;
            if (found_at >= 0) begin
               bag_size = bag_size - 1'b1;
               slot_values[found_at] = slot_values[bag_size];
            end
            queue_result(found_at >= 0, '0, '0, 1'b0, 1'b1);
         end
         OP_COUNT: begin
            for (i = 0; i < bag_size; i++)
               if (slot_values[i] == value) hits++;
            queue_result(hits != 0, COUNT_W'(hits), '0, 1'b0, 1'b1);
         end
         OP_CLEAR: begin
            bag_size = '0;
            queue_result(1'b1, '0, '0, 1'b0, 1'b1);
         end
         OP_LIST: begin
            if (bag_size == 0) begin
               queue_result(1'b1, '0, '0, 1'b0, 1'b1);
            end else begin
               for (i = 0; i < bag_size; i++)
                  queue_result(1'b1, '0, slot_values[i], 1'b1, i == bag_size - 1);
            end
         end
         default: begin
            queue_result(1'b0, '0, '0, 1'b0, 1'b1);
         end
      endcase
   endfunction

   always @(posedge clock) begin : monitor
      result_type seen;
      result_type want;
      if (reset) begin
         bag_size  = '0;
         ring_head = 0;
         ring_tail = 0;
      end else begin
         if (req_tvalid && req_tready) apply_bag_op(op_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            seen.success     = rsp_tdata[0];
            seen.match_count = rsp_tdata[5:1];
            seen.size_after  = rsp_tdata[10:6];
            seen.item_out    = rsp_tdata[42:11];
            seen.item_valid  = rsp_tuser;
            seen.last        = rsp_tlast;
            if (ring_tail == ring_head) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t ns: unexpected result, none pending, got tdata=%h user=%b last=%b",
                           $time, rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want = expected_ring[ring_head % RING_DEPTH];
               ring_head++;
               results_checked++;
               if (seen !== want || rsp_tdata[47:43] !== 5'd0) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display({"%0t ns: mismatch, expected ok=%b cnt=%0d size=%0d item=%h ",
                               "valid=%b last=%b, got ok=%b cnt=%0d size=%0d item=%h valid=%b ",
                               "last=%b pad=%h"},
                              $time, want.success, want.match_count, want.size_after,
                              want.item_out, want.item_valid, want.last, seen.success,
                              seen.match_count, seen.size_after, seen.item_out,
                              seen.item_valid, seen.last, rsp_tdata[47:43]);
               end
            end
         end
      end
      results_pending = ring_tail - ring_head;
   end

endmodule

[tb/bounded_multiset_table_tb.sv]
// Testbench top for the bag table: clock, reset, request stimulus, response
// back-pressure, watchdog and verdict. Depends on bmt_pkg, bag_result_checker
// and bounded_multiset_table.
`timescale 1ns / 1ps

module bounded_multiset_table_tb;
   import bmt_pkg::*;

   localparam int     CAPACITY         = 16;
   localparam int     WATCHDOG_LIMIT   = 5000;
   localparam int     HOLD_OFF_CYCLES  = 300;
   localparam int     DRAIN_CYCLES     = 50;
   localparam int     RANDOM_PER_PHASE = 125;
   localparam int     POOL_SIZE        = 6;
   localparam op_type OP_SPARE_LO      = 3'd5;
   localparam op_type OP_SPARE_HI      = 3'd7;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   int          mismatches;
   int          results_checked;
   int          results_pending;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_left;
   bit          hold_start;
   bit          hold_taken;
   int          items_sent;
   int          idle_cycles;
   logic [31:0] value_pool [POOL_SIZE];

   always #6 clock = ~clock;

   bounded_multiset_table #(
      .CAPACITY   (CAPACITY),
      .ITEM_WIDTH (32)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   bag_result_checker #(
      .CAPACITY (CAPACITY)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .mismatches      (mismatches),
      .results_checked (results_checked),
      .results_pending (results_pending)
   );

   // response back-pressure; a requested hold-off overrides the random stalls
   always @(negedge clock) begin
      if (hold_start && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles at %0t ns", idle_cycles, $time);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(input op_type op, input logic [31:0] value);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // mostly a small pool so that removes and counts hit; some extremes and full random
   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 15) return $urandom();
      if (r < 18) return '0;
      if (r < 21) return '1;
      if (r < 25) return 32'h1 << $urandom_range(31);
      return value_pool[$urandom_range(POOL_SIZE - 1)];
   endfunction

   function automatic op_type pick_op();
      int r;
      r = $urandom_range(99);
      if (r < 36) return OP_ADD;
      if (r < 58) return OP_REMOVE;
      if (r < 78) return OP_COUNT;
      if (r < 92) return OP_LIST;
      if (r < 96) return OP_CLEAR;
      return op_type'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
   endfunction

   task automatic send_random_items(input int sender_pct, input int receiver_pct,
                                    input int count);
      send_idle_pct  = sender_pct;
      recv_stall_pct = receiver_pct;
      repeat (count) send_item(pick_op(), pick_value());
   endtask

   initial begin
      int k;
      for (k = 0; k < POOL_SIZE; k++) value_pool[k] = $urandom();
      value_pool[0] = '0;
      value_pool[1] = '1;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty bag, duplicates, remove with move of the last entry,
      // unused code, full bag, full list, clear
      send_item(OP_LIST, $urandom());
      send_item(OP_REMOVE, 32'h7);
      send_item(OP_ADD, 32'h0);
      send_item(OP_ADD, 32'hFFFF_FFFF);
      send_item(OP_ADD, 32'h0);
      send_item(OP_COUNT, 32'h0);
      send_item(OP_COUNT, 32'h1234_5678);
      send_item(OP_REMOVE, 32'h0);
      send_item(OP_SPARE_LO, $urandom());
      for (k = 0; k < CAPACITY - 2; k++) send_item(OP_ADD, value_pool[k % POOL_SIZE]);
      send_item(OP_ADD, 32'hA5A5_A5A5);
      send_item(OP_LIST, $urandom());
      send_item(OP_CLEAR, $urandom());
      send_item(OP_SPARE_HI, $urandom());

      hold_start = 1'b1;
      send_random_items(0, 0, RANDOM_PER_PHASE);
      send_random_items(63, 0, RANDOM_PER_PHASE);
      send_random_items(0, 63, RANDOM_PER_PHASE);
      send_random_items(8, 8, RANDOM_PER_PHASE);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Run sent %0d requests over four flow-control phases, including a %0d-cycle",
               items_sent, HOLD_OFF_CYCLES);
      $display("response hold-off; %0d results checked, %0d mismatches",
               results_checked, mismatches);
      if (mismatches == 0 && results_pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
